// ===== rtl/nmea_sentence_checksum_validator_top_macros.svh =====
// Assertion macros for the NMEA sentence checksum validator checker.
// Needs clk and rst_n in the scope of use; no other dependencies.
`ifndef NMEA_SENTENCE_CHECKSUM_VALIDATOR_TOP_MACROS_SVH
`define NMEA_SENTENCE_CHECKSUM_VALIDATOR_TOP_MACROS_SVH

// same-cycle implication
`define NSCV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nscv assertion failed");

// next-cycle implication
`define NSCV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nscv assertion failed");

`endif

// ===== rtl/nscv_pkg.sv =====
// Package for the NMEA sentence checksum validator: codes, character
// constants, sizes and hex helpers. No dependencies.
package nscv_pkg;

    localparam int LINE_BUFFER_BYTES = 256;
    localparam int LIMIT_CAP         = LINE_BUFFER_BYTES - 1;
    localparam int MIN_LINE_BYTES    = 6;
    localparam int TAIL_BYTES        = 5;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CNT_MAX   = 8'hFF;

    typedef enum logic [2:0] {
        ST_VALID     = 3'd0,
        ST_NO_DOLLAR = 3'd1,
        ST_FRAMING   = 3'd2,
        ST_MISMATCH  = 3'd3,
        ST_OVERFLOW  = 3'd4
    } line_status_t;

    typedef struct packed {
        line_status_t status;
        logic [7:0]   checksum;
        logic [7:0]   length;
    } verdict_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] n8;
        n8 = {4'h0, nib};
        return (nib < 4'd10) ? (CH_ZERO + n8) : (CH_UA + n8 - 8'd10);
    endfunction

    function automatic logic is_upper_hex(input logic [7:0] c);
        return ((c >= CH_ZERO) && (c <= CH_NINE)) || ((c >= CH_UA) && (c <= CH_UF));
    endfunction

endpackage

// ===== rtl/nscv_ifs.sv =====
// Valid/ready channel interfaces: received byte, line verdict, config write.
// Depends on nothing.
interface nscv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface nscv_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] line_status;
    logic [7:0] computed_checksum;
    logic [7:0] line_length;
    modport source (output valid, output line_status, output computed_checksum,
                    output line_length, input ready);
    modport sink (input valid, input line_status, input computed_checksum,
                  input line_length, output ready);
endinterface

interface nscv_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] max_line_length;
    modport source (output valid, output max_line_length, input ready);
    modport sink (input valid, input max_line_length, output ready);
endinterface

// ===== rtl/nscv_line_check.sv =====
// Per-line state (running XOR, tail window, count, flags) and the verdict
// for a line feed. Depends on nscv_pkg.
module nscv_line_check (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic [7:0]        limit,
    output nscv_pkg::verdict_t verdict
);

    logic [7:0] xor_reg, xor_next;
    logic [7:0] win_reg [nscv_pkg::TAIL_BYTES];
    logic [7:0] win_next [nscv_pkg::TAIL_BYTES];
    logic [7:0] cnt_reg, cnt_next;
    logic       dollar_reg, dollar_next;
    logic       zero_reg, zero_next;
    logic       ovf_reg, ovf_next;
    logic [8:0] cnt_inc;
    logic       is_lf;
    logic       long_enough;
    logic [7:0] sum;
    logic       framing_bad;
    nscv_pkg::line_status_t status;

    always_comb
    begin
        cnt_inc     = {1'b0, cnt_reg} + 9'd1;
        is_lf       = (data_byte == nscv_pkg::CH_LF);
        dollar_next = (cnt_reg == 8'd0) ? (data_byte == nscv_pkg::CH_DOLLAR) : dollar_reg;
        xor_next    = (cnt_reg == 8'd0) ? xor_reg : (xor_reg ^ data_byte);
        zero_next   = zero_reg | (data_byte == 8'h00);
        ovf_next    = ovf_reg | (cnt_inc > {1'b0, limit});
        cnt_next    = cnt_inc[8] ? nscv_pkg::CNT_MAX : cnt_inc[7:0];
        for (int k = 0; k < nscv_pkg::TAIL_BYTES - 1; k++)
        begin
            win_next[k] = win_reg[k + 1];
        end
        win_next[nscv_pkg::TAIL_BYTES - 1] = data_byte;

        long_enough = (cnt_next >= 8'(nscv_pkg::MIN_LINE_BYTES));
        sum = 8'h00;
        if (long_enough)
        begin
            sum = xor_next ^ win_next[0] ^ win_next[1] ^ win_next[2]
                  ^ win_next[3] ^ win_next[4];
        end

        framing_bad = zero_next || !long_enough
                      || (win_next[0] != nscv_pkg::CH_STAR)
                      || (win_next[3] != nscv_pkg::CH_CR)
                      || !nscv_pkg::is_upper_hex(win_next[1])
                      || !nscv_pkg::is_upper_hex(win_next[2]);

        priority if (ovf_next)
            status = nscv_pkg::ST_OVERFLOW;
        else if (!dollar_next)
            status = nscv_pkg::ST_NO_DOLLAR;
        else if (framing_bad)
            status = nscv_pkg::ST_FRAMING;
        else if ((win_next[1] != nscv_pkg::hex_char(sum[7:4]))
                 || (win_next[2] != nscv_pkg::hex_char(sum[3:0])))
            status = nscv_pkg::ST_MISMATCH;
        else
            status = nscv_pkg::ST_VALID;

        verdict.status   = status;
        verdict.checksum = sum;
        verdict.length   = cnt_next;
    end

    // line feed ends the line and clears everything
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_reg    <= 8'h00;
            cnt_reg    <= 8'h00;
            dollar_reg <= 1'b0;
            zero_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
            for (int k = 0; k < nscv_pkg::TAIL_BYTES; k++)
            begin
                win_reg[k] <= 8'h00;
            end
        end
        else if (step)
        begin
            if (is_lf)
            begin
                xor_reg    <= 8'h00;
                cnt_reg    <= 8'h00;
                dollar_reg <= 1'b0;
                zero_reg   <= 1'b0;
                ovf_reg    <= 1'b0;
                for (int k = 0; k < nscv_pkg::TAIL_BYTES; k++)
                begin
                    win_reg[k] <= 8'h00;
                end
            end
            else
            begin
                xor_reg    <= xor_next;
                cnt_reg    <= cnt_next;
                dollar_reg <= dollar_next;
                zero_reg   <= zero_next;
                ovf_reg    <= ovf_next;
                for (int k = 0; k < nscv_pkg::TAIL_BYTES; k++)
                begin
                    win_reg[k] <= win_next[k];
                end
            end
        end
    end

endmodule

// ===== rtl/nmea_sentence_checksum_validator_top.sv =====
// NMEA sentence checksum validator top: input register, line checker,
// verdict register, config register. Depends on nscv_pkg, nscv_ifs, nscv_line_check.
// Order: the LF transfer loads the input register, and the verdict register is
//   loaded from it once the sink has freed that register.
// Throughput: one byte per cycle; the only stall is an LF whose verdict
//   register is still held by the sink.
// Reset (rst_n, async, active low): pipeline empty, line state cleared,
//   max_line_length = 255.
module nmea_sentence_checksum_validator_top (
    input  logic                clk,
    input  logic                rst_n,
    nscv_byte_if.sink           rx,
    nscv_result_if.source       verdict,
    nscv_cfg_if.sink            cfg
);

    // config register; limit is clamped to the line buffer size less one
    logic [7:0] max_len_reg;
    logic [7:0] limit;

    // input register
    logic       in_vld_reg;
    logic [7:0] byte_reg;

    // verdict register
    logic                 out_vld_reg, out_vld_next;
    nscv_pkg::verdict_t   out_reg;
    nscv_pkg::verdict_t   check_verdict;

    logic byte_is_lf;
    logic out_free;
    logic step;
    logic load;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= 8'hFF;
        else if (cfg.valid)
            max_len_reg <= cfg.max_line_length;
    end

    always_comb
    begin
        if (int'(max_len_reg) > nscv_pkg::LIMIT_CAP)
            limit = nscv_pkg::LIMIT_CAP[7:0];
        else
            limit = max_len_reg;
    end

    // A byte in the input register moves on unless it is an LF and the
    // verdict register is still full.
    assign byte_is_lf = (byte_reg == nscv_pkg::CH_LF);
    assign out_free   = !out_vld_reg || verdict.ready;
    assign step       = in_vld_reg && (!byte_is_lf || out_free);
    assign load       = step && byte_is_lf;
    assign rx.ready   = !in_vld_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (rx.ready)
            in_vld_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
            byte_reg <= rx.data_byte;
    end

    nscv_line_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (byte_reg),
        .limit     (limit),
        .verdict   (check_verdict)
    );

    always_comb
    begin
        if (load)
            out_vld_next = 1'b1;
        else if (verdict.ready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= check_verdict;
    end

    assign verdict.valid             = out_vld_reg;
    assign verdict.line_status       = out_reg.status;
    assign verdict.computed_checksum = out_reg.checksum;
    assign verdict.line_length       = out_reg.length;

endmodule

// ===== rtl/nscv_checker.sv =====
// Port-level checker for the validator top, bound to it below.
// Depends on nscv_pkg and the macros header.
`include "nmea_sentence_checksum_validator_top_macros.svh"

module nscv_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rx_valid,
    input logic       rx_ready,
    input logic [7:0] rx_data_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] out_status,
    input logic [7:0] out_checksum,
    input logic [7:0] out_length
);

    logic rx_wait;
    logic out_stall;
    logic valid_verdict;
    logic short_verdict;
    logic short_ok;

    assign rx_wait       = rx_valid && !rx_ready;
    assign out_stall     = out_valid && !out_ready;
    assign valid_verdict = out_valid && (out_status == nscv_pkg::ST_VALID);
    assign short_verdict = out_valid && (out_length < 8'(nscv_pkg::MIN_LINE_BYTES));
    assign short_ok      = (out_checksum == 8'h00)
                           && (out_status != nscv_pkg::ST_VALID)
                           && (out_status != nscv_pkg::ST_MISMATCH);

    // held verdict length and status do not change while stalled
    `NSCV_ASSERT_NEXT(a_hold, out_stall, out_valid && $stable(out_length) && $stable(out_status))

    // a waiting byte keeps its value until transferred
    `NSCV_ASSERT_NEXT(a_rx_hold, rx_wait, rx_valid && $stable(rx_data_byte))

    // input only blocks behind a verdict the sink is holding off
    `NSCV_ASSERT_NOW(a_rx_block, !rx_ready, out_stall)

    // a valid line is at least the minimum length
    `NSCV_ASSERT_NOW(a_valid_len, valid_verdict, out_length >= 8'(nscv_pkg::MIN_LINE_BYTES))

    // short lines carry no checksum and are neither valid nor a mismatch
    `NSCV_ASSERT_NOW(a_short_sum, short_verdict, short_ok)

endmodule

bind nmea_sentence_checksum_validator_top nscv_checker u_nscv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_valid     (rx.valid),
    .rx_ready     (rx.ready),
    .rx_data_byte (rx.data_byte),
    .out_valid    (verdict.valid),
    .out_ready    (verdict.ready),
    .out_status   (verdict.line_status),
    .out_checksum (verdict.computed_checksum),
    .out_length   (verdict.line_length)
);

// ===== test/nmea_sentence_checksum_validator_top_test.sv =====
// Self-checking testbench for nmea_sentence_checksum_validator_top: drives byte
// streams of NMEA lines, predicts each line verdict and checks it per field.
// Depends on nscv_pkg, the nscv_* channel interfaces and the top-level RTL.
module nmea_sentence_checksum_validator_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    // generous bound: a full run is ~1000 bytes
    localparam int CYCLE_LIMIT = 400000;
    // settling after the last verdict before a limit write or the end of run
    localparam int SETTLE_CYCLES = 4;

    typedef enum int {
        FL_NONE,
        FL_BAD_SUM,
        FL_LOWER,
        FL_NO_DOLLAR,
        FL_ZERO,
        FL_NO_CR,
        FL_NO_STAR
    } line_flaw_t;

    logic clk = 1'b0;
    logic rst_n;

    nscv_byte_if   rx_ch ();
    nscv_result_if verdict_ch ();
    nscv_cfg_if    cfg_ch ();

    nmea_sentence_checksum_validator_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .verdict (verdict_ch),
        .cfg     (cfg_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line verdict predictor: shadow of the per-line state and the limit.
    // ------------------------------------------------------------------
    logic [7:0]  limit_shadow;
    logic [7:0]  run_xor;
    logic [7:0]  tail_bytes [nscv_pkg::TAIL_BYTES];
    int unsigned line_count;
    bit          got_dollar;
    bit          got_zero;
    bit          got_overflow;

    nscv_pkg::verdict_t expected_verdicts [$];
    int          mismatch_count = 0;
    int unsigned cycle_count = 0;

    int          src_idle_pct = 0;
    int          rx_stall_pct = 0;

    logic [7:0]  pending_line [$];

    function automatic logic [7:0] nib_to_char(input logic [3:0] n);
        string digits;
        digits = "0123456789ABCDEF";
        return digits[n];
    endfunction

    function automatic bit upper_hex_char(input logic [7:0] c);
        for (int i = 0; i < 16; i++)
        begin
            if (c == nib_to_char(i[3:0]))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic clear_line_state();
        run_xor      = 8'h00;
        line_count   = 0;
        got_dollar   = 1'b0;
        got_zero     = 1'b0;
        got_overflow = 1'b0;
        for (int k = 0; k < nscv_pkg::TAIL_BYTES; k++)
            tail_bytes[k] = 8'h00;
    endtask

    // Fold one accepted byte into the line state; on LF queue the verdict.
    task automatic predict_byte(input logic [7:0] b);
        int unsigned            cap;
        logic [7:0]             sum;
        nscv_pkg::line_status_t st;
        nscv_pkg::verdict_t     v;
        cap = (limit_shadow > nscv_pkg::LIMIT_CAP) ? nscv_pkg::LIMIT_CAP : limit_shadow;
        if (line_count == 0)
        begin
            if (b == nscv_pkg::CH_DOLLAR)
                got_dollar = 1'b1;
        end
        else
            run_xor ^= b;
        if (b == 8'h00)
            got_zero = 1'b1;
        if (line_count + 1 > cap)
            got_overflow = 1'b1;
        line_count = (line_count + 1 > 255) ? 255 : line_count + 1;
        for (int k = 0; k < nscv_pkg::TAIL_BYTES - 1; k++)
            tail_bytes[k] = tail_bytes[k + 1];
        tail_bytes[nscv_pkg::TAIL_BYTES - 1] = b;

        if (b != nscv_pkg::CH_LF)
            return;

        // running XOR minus the last five bytes leaves the '$'..'*' span
        sum = 8'h00;
        if (line_count >= nscv_pkg::MIN_LINE_BYTES)
        begin
            sum = run_xor;
            for (int k = 0; k < nscv_pkg::TAIL_BYTES; k++)
                sum ^= tail_bytes[k];
        end

        if (got_overflow)
            st = nscv_pkg::ST_OVERFLOW;
        else if (!got_dollar)
            st = nscv_pkg::ST_NO_DOLLAR;
        else if (got_zero || line_count < nscv_pkg::MIN_LINE_BYTES ||
                 tail_bytes[0] != nscv_pkg::CH_STAR || tail_bytes[3] != nscv_pkg::CH_CR ||
                 !upper_hex_char(tail_bytes[1]) || !upper_hex_char(tail_bytes[2]))
            st = nscv_pkg::ST_FRAMING;
        else if (tail_bytes[1] != nib_to_char(sum[7:4]) ||
                 tail_bytes[2] != nib_to_char(sum[3:0]))
            st = nscv_pkg::ST_MISMATCH;
        else
            st = nscv_pkg::ST_VALID;

        v.status   = st;
        v.checksum = sum;
        v.length   = line_count[7:0];
        expected_verdicts.insert(expected_verdicts.size(), v);
        clear_line_state();
    endtask

    // ------------------------------------------------------------------
    // Verdict channel: random backpressure and the per-field comparison.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        nscv_pkg::verdict_t exp_v;
        if (rst_n === 1'b1 && verdict_ch.valid === 1'b1 && verdict_ch.ready === 1'b1)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: verdict with none expected: status %0d checksum %02h length %0d",
                         $time, verdict_ch.line_status, verdict_ch.computed_checksum,
                         verdict_ch.line_length);
                mismatch_count++;
            end
            else
            begin
                exp_v = expected_verdicts.pop_front();
                if (verdict_ch.line_status !== exp_v.status)
                begin
                    $display("%0t: line_status expected %0d actual %0d",
                             $time, exp_v.status, verdict_ch.line_status);
                    mismatch_count++;
                end
                if (verdict_ch.computed_checksum !== exp_v.checksum)
                begin
                    $display("%0t: computed_checksum expected %02h actual %02h",
                             $time, exp_v.checksum, verdict_ch.computed_checksum);
                    mismatch_count++;
                end
                if (verdict_ch.line_length !== exp_v.length)
                begin
                    $display("%0t: line_length expected %0d actual %0d",
                             $time, exp_v.length, verdict_ch.line_length);
                    mismatch_count++;
                end
            end
        end
        verdict_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d verdicts outstanding", $time, expected_verdicts.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Byte sender and helpers.
    // ------------------------------------------------------------------

    // Idle gaps lower valid while each random draw falls below src_idle_pct; after a
    // transfer valid is left high so back-to-back bytes never toggle it within one time step.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid     <= 1'b1;
        rx_ch.data_byte <= b;
        do
            @(posedge clk);
        while (rx_ch.ready !== 1'b1);
        predict_byte(b);
    endtask

    task automatic send_line();
        foreach (pending_line[i])
            send_byte(pending_line[i]);
        pending_line = {};
    endtask

    // body followed by CR LF
    task automatic send_sentence(input string body);
        for (int i = 0; i < body.len(); i++)
            send_byte(body[i]);
        send_byte(nscv_pkg::CH_CR);
        send_byte(nscv_pkg::CH_LF);
    endtask

    // Hold off the sender until every verdict is in, then let the pipeline settle.
    task automatic drain_results();
        rx_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called right after drain_results, so the block is idle.
    task automatic write_limit(input logic [7:0] value);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.max_line_length <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        limit_shadow = value;
    endtask

    // Sentence "$<payload>*HH\r\n" with an optional defect.
    task automatic make_sentence(input int payload_len, input line_flaw_t flaw);
        logic [7:0] c;
        logic [7:0] csum;
        logic [7:0] hi;
        logic [7:0] lo;
        string      lower_hex;
        lower_hex    = "abcdef";
        pending_line = {};
        csum         = 8'h00;
        if (flaw == FL_NO_DOLLAR)
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == nscv_pkg::CH_DOLLAR || c == nscv_pkg::CH_LF);
            pending_line.insert(pending_line.size(), c);
        end
        else
            pending_line.insert(pending_line.size(), nscv_pkg::CH_DOLLAR);
        for (int i = 0; i < payload_len; i++)
        begin
            c = 8'($urandom_range(8'h20, 8'h7E));
            csum ^= c;
            pending_line.insert(pending_line.size(), c);
        end
        if (flaw == FL_ZERO)
            pending_line.insert($urandom_range(1, pending_line.size()), 8'h00);
        if (flaw == FL_NO_STAR)
        begin
            do
                c = 8'($urandom_range(8'h20, 8'h7E));
            while (c == nscv_pkg::CH_STAR);
            pending_line.insert(pending_line.size(), c);
        end
        else
            pending_line.insert(pending_line.size(), nscv_pkg::CH_STAR);
        hi = nib_to_char(csum[7:4]);
        lo = nib_to_char(csum[3:0]);
        if (flaw == FL_BAD_SUM)
            lo = nib_to_char(csum[3:0] ^ 4'($urandom_range(1, 15)));
        else if (flaw == FL_LOWER)
            lo = lower_hex[$urandom_range(0, 5)];
        pending_line.insert(pending_line.size(), hi);
        pending_line.insert(pending_line.size(), lo);
        if (flaw == FL_NO_CR)
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == nscv_pkg::CH_CR || c == nscv_pkg::CH_LF);
            pending_line.insert(pending_line.size(), c);
        end
        else
            pending_line.insert(pending_line.size(), nscv_pkg::CH_CR);
        pending_line.insert(pending_line.size(), nscv_pkg::CH_LF);
    endtask

    // Mostly well-formed sentences, some defective ones, some raw noise.
    task automatic make_random_line();
        int         pick;
        int         len;
        line_flaw_t flaw;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            len  = ($urandom_range(0, 49) == 0) ? $urandom_range(150, 300) : $urandom_range(0, 20);
            pick = $urandom_range(0, 99);
            flaw = (pick < 80) ? FL_NONE : (pick < 90) ? FL_BAD_SUM : FL_LOWER;
            make_sentence(len, flaw);
        end
        else if (pick < 85)
        begin
            flaw = line_flaw_t'($urandom_range(FL_NO_DOLLAR, FL_NO_STAR));
            make_sentence($urandom_range(0, 20), flaw);
        end
        else
        begin
            // raw bytes; any embedded LF simply splits the line
            pending_line = {};
            len = $urandom_range(0, 30);
            for (int i = 0; i < len; i++)
                pending_line.insert(pending_line.size(), 8'($urandom_range(0, 255)));
            pending_line.insert(pending_line.size(), nscv_pkg::CH_LF);
        end
    endtask

    task automatic run_random_phase(input int src_pct, input int snk_pct,
                                    input logic [7:0] limit, input int n_bytes);
        int sent;
        drain_results();
        write_limit(limit);
        src_idle_pct = src_pct;
        rx_stall_pct = snk_pct;
        sent         = 0;
        while (sent < n_bytes)
        begin
            make_random_line();
            sent += pending_line.size();
            send_line();
            // now and then the sender waits for every verdict to come back
            if ($urandom_range(0, 11) == 0)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // empty line, short line, minimal valid, lowercase digit, wrong sum, zero byte
    task automatic test_directed_lines();
        send_byte(nscv_pkg::CH_LF);
        send_byte(nscv_pkg::CH_DOLLAR);
        send_byte(nscv_pkg::CH_LF);
        send_sentence("$*00");
        send_sentence("$*0a");
        send_sentence("$*01");
        send_byte(nscv_pkg::CH_DOLLAR);
        send_byte(8'h00);
        send_sentence("*00");
    endtask

    // smallest limits, then exact fit and saturation at the reset limit
    task automatic test_line_limit_extremes();
        drain_results();
        write_limit(8'd6);
        send_sentence("$*00");
        send_sentence("$J*4A");
        drain_results();
        write_limit(8'd0);
        send_byte(nscv_pkg::CH_LF);
        send_sentence("$*00");
        drain_results();
        write_limit(8'd5);
        send_sentence("$*00");
        drain_results();
        write_limit(8'd255);
        make_sentence(249, FL_NONE);
        send_line();
        make_sentence(294, FL_NONE);
        send_line();
    endtask

    task automatic test_no_idling();
        run_random_phase(0, 0, 8'd255, 65);
    endtask

    task automatic test_sender_gaps();
        run_random_phase(71, 0, 8'd24, 65);
    endtask

    task automatic test_receiver_stalls();
        run_random_phase(0, 71, 8'($urandom_range(6, 255)), 65);
    endtask

    task automatic test_both_stalling();
        run_random_phase(27, 27, 8'd40, 65);
    endtask

    task automatic test_back_to_back();
        run_random_phase(0, 0, 8'($urandom_range(0, 255)), 65);
    endtask

    initial
    begin
        rst_n                  <= 1'b0;
        rx_ch.valid            <= 1'b0;
        rx_ch.data_byte        <= 8'h00;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.max_line_length <= 8'h00;
        limit_shadow = 8'd255;
        clear_line_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_lines();
        test_line_limit_extremes();
        test_no_idling();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_stalling();
        test_back_to_back();

        // all bytes are in; wait out the last verdicts and the pipeline
        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
